>>> rtl/assert_macros.svh
// assertion macros used by the checker file pic_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PIC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PIC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

>>> rtl/pic_pkg.sv
// shared types and constants of the platform interrupt controller
package pic_pkg;

	localparam int NUM_SOURCES_DEF   = 256;
	localparam int PRIORITY_BITS_DEF = 3;
	localparam int THR_W             = 3;
	localparam int ID_W              = 8;
	localparam int WORD_W            = 32;

	typedef enum logic [1:0] {
		FUNC_LINE     = 2'd0,
		FUNC_COMPLETE = 2'd1,
		FUNC_PRIO     = 2'd2,
		FUNC_ENABLE   = 2'd3
	} pic_func_t;

	typedef struct packed {
		pic_func_t         func;
		logic [ID_W-1:0]   source_id;
		logic              line_level;
		logic [2:0]        priority_value;
		logic [2:0]        enable_index;
		logic [WORD_W-1:0] enable_mask;
	} pic_item_t;

	typedef struct packed {
		logic [ID_W-1:0] claim_id;
		logic            core_irq;
	} pic_result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} pic_state_t;

endpackage

>>> rtl/platform_interrupt_controller_unit.sv
// single-context interrupt controller top level with sequential arbitration scan
// writes, and line changes that start no arbitration, go from ST_IDLE straight to ST_DONE;
// when arbitration runs it goes through ST_SCAN (one priority memory read per source from 1
// up), ST_FINISH and ST_DONE; a new request is taken only after the result has been loaded
// after reset a sweep in ST_CLEAR zeroes the priority memory, item_ready low
// threshold writes are taken in every cycle
module platform_interrupt_controller_unit #(
	parameter int NUM_SOURCES   = pic_pkg::NUM_SOURCES_DEF,
	parameter int PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  pic_pkg::pic_item_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output pic_pkg::pic_result_t       result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pic_pkg::THR_W-1:0]  cfg_threshold
);
	import pic_pkg::*;

	localparam int IDX_W        = $clog2(NUM_SOURCES);
	localparam int SRC_W        = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
	localparam int PW           = (PRIORITY_BITS > THR_W) ? PRIORITY_BITS : THR_W;
	localparam int ENABLE_WORDS = NUM_SOURCES / WORD_W;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SOURCES - 1);
	localparam logic [SRC_W-1:0] SRC_LIMIT = SRC_W'(NUM_SOURCES);
	localparam logic [NUM_SOURCES-1:0] NO_SRC0 = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

	pic_state_t state_q, state_d;

	logic [IDX_W-1:0]       cnt_q;
	logic [NUM_SOURCES-1:0] line_q;
	logic [NUM_SOURCES-1:0] pend_q;
	logic [NUM_SOURCES-1:0] en_q;
	logic [THR_W-1:0]       thr_q;
	logic [ID_W-1:0]        claim_q;
	logic                   irq_q;
	logic                   result_valid_q;
	pic_result_t            result_q;

	logic [PRIORITY_BITS-1:0] prio_mem [NUM_SOURCES];
	logic [PRIORITY_BITS-1:0] prio_rd_s1;
	logic                     pend_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     vld_s1;

	logic [IDX_W-1:0] best_q;
	logic [PW-1:0]    best_prio_q;

	logic                     accept;
	logic [SRC_W-1:0]         src_w;
	logic                     src_ok;
	logic [IDX_W-1:0]         src_idx;
	logic [NUM_SOURCES-1:0]   line_new;
	logic                     rising;
	logic [NUM_SOURCES-1:0]   mark_vec;
	logic                     marked;
	logic                     do_line;
	logic                     do_complete;
	logic                     go_scan;

	logic                     mem_clear;
	logic                     scan_issue;
	logic                     finish;
	logic                     load_result;
	logic                     mem_we;
	logic [IDX_W-1:0]         mem_wa;
	logic [PRIORITY_BITS-1:0] mem_wd;

	logic [PW-1:0]    p_ext;
	logic [PW-1:0]    thr_ext;
	logic             hit;
	logic [IDX_W-1:0] best_d;

	// request decode
	assign accept      = item_valid && item_ready;
	assign src_w       = SRC_W'(item.source_id);
	assign src_ok      = src_w < SRC_LIMIT;
	assign src_idx     = src_w[IDX_W-1:0];
	assign rising      = !line_q[src_idx] && item.line_level;
	assign do_line     = accept && (item.func == FUNC_LINE) && src_ok;
	assign do_complete = accept && (item.func == FUNC_COMPLETE) && src_ok;

	always_comb begin
		line_new = line_q;
		line_new[src_idx] = item.line_level;
	end

	assign mark_vec = en_q & line_new & NO_SRC0;
	assign marked   = |mark_vec;
	assign go_scan  = (do_line && rising && marked) || do_complete;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = go_scan ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready  = 1'b0;
		mem_clear   = 1'b0;
		scan_issue  = 1'b0;
		finish      = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			ST_CLEAR:  mem_clear = 1'b1;
			ST_IDLE:   item_ready = 1'b1;
			ST_SCAN:   scan_issue = 1'b1;
			ST_FINISH: finish = 1'b1;
			ST_DONE:   load_result = !result_valid_q || result_ready;
			default:   item_ready = 1'b0;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// priority memory port
	assign mem_we = mem_clear || (accept && (item.func == FUNC_PRIO) && src_ok);
	assign mem_wa = mem_clear ? cnt_q : src_idx;
	assign mem_wd = mem_clear ? '0 : PRIORITY_BITS'(item.priority_value);

	always_ff @(posedge clk) begin
		if (mem_we) prio_mem[mem_wa] <= mem_wd;
		prio_rd_s1 <= prio_mem[cnt_q];
	end

	// compare stage of the scan
	assign p_ext   = PW'(prio_rd_s1);
	assign thr_ext = PW'(thr_q);
	assign hit     = vld_s1 && pend_s1 && (p_ext > thr_ext) && (p_ext > best_prio_q);
	assign best_d  = hit ? idx_s1 : best_q;

	always_ff @(posedge clk) begin
		pend_s1 <= pend_q[cnt_q];
		idx_s1  <= cnt_q;
		if (accept) begin
			best_q      <= '0;
			best_prio_q <= '0;
		end else if (hit) begin
			best_q      <= idx_s1;
			best_prio_q <= p_ext;
		end
		if (load_result) result_q <= '{claim_id: claim_q, core_irq: irq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			vld_s1         <= 1'b0;
			line_q         <= '0;
			pend_q         <= '0;
			en_q           <= '0;
			thr_q          <= '0;
			claim_q        <= '0;
			irq_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;

			if (mem_clear || scan_issue) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end else if (accept) begin
				cnt_q <= IDX_W'(1);
			end

			if (cfg_valid) thr_q <= cfg_threshold;

			if (do_line) begin
				line_q[src_idx] <= item.line_level;
				if (rising) pend_q <= pend_q | mark_vec;
			end

			if (do_complete) begin
				pend_q[src_idx] <= 1'b0;
				irq_q           <= 1'b0;
			end

			for (int w = 0; w < ENABLE_WORDS; w++) begin
				if (accept && (item.func == FUNC_ENABLE) && (32'(item.enable_index) == w)) begin
					en_q[w*WORD_W +: WORD_W] <= item.enable_mask;
				end
			end

			if (finish) begin
				claim_q <= ID_W'(best_d);
				if (best_d != '0) irq_q <= 1'b1;
			end

			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/pic_checker.sv
// port-level checker of the interrupt controller and its bind
`include "assert_macros.svh"

module pic_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input pic_pkg::pic_result_t result
);
	import pic_pkg::*;

	// a stalled result holds
	`PIC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// a nonzero claim only ever goes out with the interrupt raised
	`PIC_ASSERT_SAME(a_claim_irq, result_valid && (result.claim_id != '0), result.core_irq)

	// every request makes the block busy: item_ready drops and no new result is raised yet
	`PIC_ASSERT_NEXT(a_busy_after_req, item_valid && item_ready, !item_ready && !$rose(result_valid))

endmodule

bind platform_interrupt_controller_unit pic_checker u_pic_checker (.*);
